// ----- hdl/sha256_pkg.sv -----
// SHA-256 hasher package: types, constants and round functions.
package sha256_pkg;

  localparam int unsigned LEN_POS = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  // queue entry between front and back
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       last_byte;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } state_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    begin
      unique case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64];
    begin
      k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
    end
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hdl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level.
//  channel | dir | payload
//  in_     | in  | tdata = msg_byte, tuser = byte_present, tlast = last_byte
//  out_    | out | tdata = digest_word, tuser = word_index, tlast = last_word
// Bytes fill a block; a full block is compressed by the one-round-per-cycle
// engine. A closing item adds one or two padded blocks, then eight output
// items. Reset restores the initial hash. Input stalls when the
// two-entry queue is full; output stall holds the round engine in emit.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item.msg_byte     = in_tdata;
  assign in_item.byte_present = in_tuser;
  assign in_item.last_byte    = in_tlast;

  sha256_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  sha256_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready,
    .out_word(out_tdata), .out_index(out_tuser), .out_last(out_tlast)
  );

endmodule

// ----- hdl/sha256_front.sv -----
// SHA-256 front end: input handshake and a two-entry item queue.
module sha256_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sha256_pkg::item_t   in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output sha256_pkg::item_t   q_item
);
  import sha256_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && (in_item.byte_present || in_item.last_byte);
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

endmodule

// ----- hdl/sha256_back.sv -----
// SHA-256 back end: block buffer, round engine, padding and digest output.
module sha256_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sha256_pkg::item_t  q_item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_word,
  output logic [2:0]         out_index,
  output logic               out_last
);
  import sha256_pkg::*;

  state_t      state_r, state_nxt;
  word_t       w_r [16];
  word_t       h_r [8];
  word_t       v_r [8];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [63:0] total_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic        len_done_r;
  logic        pad_stage_r;
  logic [2:0]  oidx_r;

  word_t w_cur, w_new, t1, t2, s0, s1;
  logic  take, comp_end, len_blk;

  assign q_ready    = (state_r == ST_IDLE);
  assign take       = q_valid && q_ready;
  assign comp_end   = (state_r == ST_COMP) && (rnd_r == 6'd63);
  assign len_blk    = pad_stage_r || (fill_r < 6'(LEN_POS));
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_word   = h_r[oidx_r];
  assign out_index  = oidx_r;
  assign out_last   = (oidx_r == 3'd7);

  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    w_cur = w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + w_cur;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_item.byte_present && fill_r == 6'd63) state_nxt = ST_COMP;
          else if (q_item.last_byte) state_nxt = ST_PAD;
        end
      end
      ST_COMP: begin
        if (comp_end) begin
          if (!fin_r) state_nxt = ST_IDLE;
          else if (len_done_r) state_nxt = ST_EMIT;
          else state_nxt = ST_PAD;
        end
      end
      ST_PAD:  state_nxt = ST_COMP;
      ST_EMIT: begin
        if (out_tready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // w_r holds the 16-word window; the buffer bytes are written into it directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      bits_r      <= '0;
      fin_r       <= 1'b0;
      len_done_r  <= 1'b0;
      pad_stage_r <= 1'b0;
      oidx_r      <= '0;
      rnd_r       <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          pad_stage_r <= 1'b0;
          if (take) begin
            if (q_item.byte_present) begin
              w_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= q_item.msg_byte;
              fill_r <= fill_r + 6'd1;
              if (fill_r == 6'd63) begin
                bits_r <= bits_r + 64'd512;
                rnd_r  <= '0;
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              end
            end
            fin_r      <= q_item.last_byte;
            len_done_r <= 1'b0;
            total_r    <= (q_item.byte_present && fill_r == 6'd63) ? bits_r + 64'd512 :
                          bits_r + {55'd0, fill_r + {5'd0, q_item.byte_present}, 3'd0};
          end
        end
        ST_PAD: begin
          // build final block(s) from pending bytes
          for (int i = 0; i < 16; i++) begin
            if (!(len_blk && i >= 14)) begin
              for (int b = 0; b < 4; b++) begin
                if (pad_stage_r == 1'b0) begin
                  if (6'(4*i+b) == fill_r) w_r[i][8*(3-b) +: 8] <= PAD_BYTE;
                  else if (6'(4*i+b) > fill_r) w_r[i][8*(3-b) +: 8] <= 8'h00;
                end else begin
                  w_r[i][8*(3-b) +: 8] <= 8'h00;
                end
              end
            end
          end
          if (len_blk) begin
            w_r[14]    <= total_r[63:32];
            w_r[15]    <= total_r[31:0];
            len_done_r <= 1'b1;
          end else begin
            pad_stage_r <= 1'b1;
          end
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        ST_COMP: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (comp_end) begin
            h_r[0] <= h_r[0] + t1 + t2;
            h_r[1] <= h_r[1] + v_r[0];
            h_r[2] <= h_r[2] + v_r[1];
            h_r[3] <= h_r[3] + v_r[2];
            h_r[4] <= h_r[4] + v_r[3] + t1;
            h_r[5] <= h_r[5] + v_r[4];
            h_r[6] <= h_r[6] + v_r[5];
            h_r[7] <= h_r[7] + v_r[6];
          end
        end
        ST_EMIT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              fill_r <= '0;
              bits_r <= '0;
              fin_r  <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
